// ----- hdl/tafifo_pkg.sv -----
// shared types and constants for the timestamped audio frame fifo
`timescale 1ns / 1ps

package tafifo_pkg;

   localparam int DEPTH      = 1024;
   localparam int MAX_READ   = 64;
   localparam int SLOT_W     = $clog2(DEPTH);
   localparam int CNT_W      = 11;
   localparam int RD_W       = 7;
   localparam int CSR_ADDR_W = 3;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_DROP  = 2'd2,
      ACT_RESET = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_READ    = 3'd0,
      ST_ACCEPT  = 3'd1,
      ST_OVERRUN = 3'd2,
      ST_INVALID = 3'd3,
      ST_REFUSED = 3'd4,
      ST_DONE    = 3'd5
   } status_type;

   typedef enum logic {
      REG_CAPACITY = 1'b0,
      REG_CHANNELS = 1'b1
   } reg_index_type;

   typedef struct packed {
      action_type         action;
      logic [31:0]        sample_left;
      logic [31:0]        sample_right;
      logic               block_first;
      logic [CNT_W-1:0]   block_frames;
      logic [63:0]        first_pts;
      logic [RD_W-1:0]    read_frames;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [31:0]        out_left;
      logic [31:0]        out_right;
      logic [63:0]        out_pts;
      logic               last;
      logic               continuous;
      logic [CNT_W-1:0]   queued;
      logic [31:0]        overrun_count;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic rd_issue;
      logic rd_load;
      logic rd_last;
      logic streaming;
   } ctrl_cmd_type;

   typedef struct packed {
      logic            rsp_valid;
      logic            read_stream;
      logic [RD_W-1:0] read_n;
   } dp_sts_type;

endpackage

// ----- hdl/tafifo_ctrl.sv -----
// sequencer: word acceptance and read frame streaming
`timescale 1ns / 1ps

module tafifo_ctrl import tafifo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         rsp_stall,
   input  dp_sts_type   sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_STREAM
   } state_type;

   state_type       state_ff, state_in;
   logic [RD_W-1:0] cnt_ff, cnt_in;
   logic            out_free;

   assign out_free = !sts.rsp_valid || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall  = !out_free;
            cmd.accept = req_valid && out_free;
            if (cmd.accept && sts.read_stream) begin
               cmd.rd_issue = 1'b1;
               cnt_in       = sts.read_n;
               state_in     = S_STREAM;
            end
         end
         S_STREAM: begin
            cmd.streaming = 1'b1;
            if (out_free) begin
               cmd.rd_load = 1'b1;
               cmd.rd_last = (cnt_ff == RD_W'(1));
               if (cmd.rd_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_issue = 1'b1;
                  cnt_in       = cnt_ff - RD_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- hdl/tafifo_dp.sv -----
// datapath: frame ring, pointers, block bookkeeping, csr and result register
`timescale 1ns / 1ps

module tafifo_dp import tafifo_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_word,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output rsp_type               rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   input  ctrl_cmd_type          cmd,
   output dp_sts_type            sts
);

   typedef enum logic [1:0] {
      V_IDLE    = 2'd0,
      V_ACCEPT  = 2'd1,
      V_OVERRUN = 2'd2,
      V_INVALID = 2'd3
   } verdict_type;

   logic [127:0]      mem [DEPTH];
   logic [127:0]      mem_q_ff;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [127:0]      mem_wdata;

   logic [CNT_W-1:0]  capacity_ff, capacity_in;
   logic [1:0]        channels_ff, channels_in;
   logic [SLOT_W-1:0] write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0] read_slot_ff, read_slot_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [31:0]       overrun_ff, overrun_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   verdict_type       verdict_ff, verdict_in;
   logic [SLOT_W-1:0] offset_ff, offset_in;
   logic [63:0]       stamp_ff, stamp_in;
   logic [CNT_W-1:0]  blen_ff, blen_in;
   logic [63:0]       prev_pts_ff, prev_pts_in;
   logic              cont_ff, cont_in;
   logic              first_rd_ff, first_rd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_word_ff, rsp_word_in;

   logic [CNT_W-1:0]  cap_eff;
   logic              mono;
   logic              csr_wr;
   logic              single;
   status_type        res_status;
   logic [63:0]       rd_pts;
   logic              rd_cont;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] n;
      n = CNT_W'(s) + CNT_W'(1);
      return (n >= cap) ? '0 : n[SLOT_W-1:0];
   endfunction

   assign cap_eff = (capacity_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_ff;
   assign mono    = (channels_ff == 2'd1);
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;

   assign sts.rsp_valid   = rsp_valid_ff;
   assign sts.read_n      = req_word.read_frames;
   assign sts.read_stream = (req_word.action == ACT_READ)
                            && (req_word.read_frames != '0)
                            && (req_word.read_frames <= RD_W'(MAX_READ))
                            && (fill_ff >= CNT_W'(req_word.read_frames));
   assign single = cmd.accept && !sts.read_stream;

   assign rd_pts  = mem_q_ff[127:64];
   assign rd_cont = first_rd_ff || (cont_ff && (rd_pts == prev_pts_ff + 64'd1));

   always_comb begin
      logic [CNT_W-1:0]  rem;
      logic [CNT_W-1:0]  room;
      logic [CNT_W-1:0]  n;
      verdict_type       verd;
      logic [SLOT_W-1:0] off;
      logic [63:0]       stp;
      logic [CNT_W-1:0]  blen;
      capacity_in   = capacity_ff;
      channels_in   = channels_ff;
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      fill_in       = fill_ff;
      overrun_in    = overrun_ff;
      remain_in     = remain_ff;
      verdict_in    = verdict_ff;
      offset_in     = offset_ff;
      stamp_in      = stamp_ff;
      blen_in       = blen_ff;
      prev_pts_in   = prev_pts_ff;
      cont_in       = cont_ff;
      first_rd_in   = first_rd_ff;
      mem_we        = 1'b0;
      mem_waddr     = offset_ff;
      mem_wdata     = '0;
      res_status    = ST_DONE;
      rem           = remain_ff;
      verd          = verdict_ff;
      off           = offset_ff;
      stp           = stamp_ff;
      blen          = blen_ff;
      n             = req_word.block_frames;
      room          = (fill_ff >= cap_eff) ? '0 : cap_eff - fill_ff;

      if (cmd.accept) begin
         case (req_word.action)
            ACT_WRITE: begin
               if (req_word.block_first) begin
                  rem  = n;
                  off  = write_slot_ff;
                  stp  = req_word.first_pts;
                  blen = n;
                  if (n == '0 || n > cap_eff) begin
                     verd = V_INVALID;
                  end else if (n > room) begin
                     verd = V_OVERRUN;
                     if (overrun_ff != '1) begin
                        overrun_in = overrun_ff + 32'd1;
                     end
                  end else begin
                     verd = V_ACCEPT;
                  end
               end
               if (!req_word.block_first && remain_ff == '0) begin
                  // stray frame outside any block
                  res_status = ST_INVALID;
               end else if (rem == '0) begin
                  // empty block
                  res_status = ST_INVALID;
                  remain_in  = rem;
                  verdict_in = V_IDLE;
                  offset_in  = off;
                  stamp_in   = stp;
                  blen_in    = blen;
               end else begin
                  res_status = status_type'({1'b0, verd});
                  if (verd == V_ACCEPT) begin
                     mem_we    = 1'b1;
                     mem_waddr = off;
                     mem_wdata = {stp,
                                  (mono ? 32'd0 : req_word.sample_right),
                                  req_word.sample_left};
                     off       = next_slot(off, cap_eff);
                     stp       = stp + 64'd1;
                  end
                  rem = rem - CNT_W'(1);
                  if (rem == '0) begin
                     if (verd == V_ACCEPT) begin
                        fill_in       = fill_ff + blen;
                        write_slot_in = off;
                     end
                     verdict_in = V_IDLE;
                  end else begin
                     verdict_in = verd;
                  end
                  remain_in = rem;
                  offset_in = off;
                  stamp_in  = stp;
                  blen_in   = blen;
               end
            end
            ACT_READ: begin
               if (req_word.read_frames == '0) begin
                  res_status = ST_DONE;
               end else if (!sts.read_stream) begin
                  res_status = ST_REFUSED;
               end else begin
                  fill_in     = fill_ff - CNT_W'(req_word.read_frames);
                  first_rd_in = 1'b1;
               end
            end
            ACT_DROP: begin
               read_slot_in = write_slot_ff;
               fill_in      = '0;
            end
            ACT_RESET: begin
               read_slot_in  = '0;
               write_slot_in = '0;
               fill_in       = '0;
               remain_in     = '0;
               verdict_in    = V_IDLE;
               offset_in     = '0;
               stamp_in      = '0;
            end
            default: res_status = ST_DONE;
         endcase
      end

      if (cmd.rd_issue) begin
         read_slot_in = next_slot(read_slot_ff, cap_eff);
      end

      if (cmd.rd_load) begin
         prev_pts_in = rd_pts;
         cont_in     = rd_cont;
         first_rd_in = 1'b0;
      end

      if (csr_wr) begin
         case (reg_index_type'(csr_paddr[2]))
            REG_CAPACITY: begin
               capacity_in = csr_pwdata[CNT_W-1:0];
               remain_in   = '0;
               verdict_in  = V_IDLE;
               offset_in   = '0;
               stamp_in    = '0;
            end
            REG_CHANNELS: channels_in = csr_pwdata[1:0];
            default: channels_in = channels_ff;
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (single) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in               = '0;
         rsp_word_in.status        = res_status;
         rsp_word_in.last          = 1'b1;
         rsp_word_in.queued        = fill_in;
         rsp_word_in.overrun_count = overrun_in;
      end else if (cmd.rd_load) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.status        = ST_READ;
         rsp_word_in.out_left      = mem_q_ff[31:0];
         rsp_word_in.out_right     = mono ? 32'd0 : mem_q_ff[63:32];
         rsp_word_in.out_pts       = rd_pts;
         rsp_word_in.last          = cmd.rd_last;
         rsp_word_in.continuous    = cmd.rd_last && rd_cont;
         rsp_word_in.queued        = fill_ff;
         rsp_word_in.overrun_count = overrun_ff;
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[2]))
         REG_CAPACITY: csr_prdata = 32'(capacity_ff);
         REG_CHANNELS: csr_prdata = 32'(channels_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_issue) begin
         mem_q_ff <= mem[read_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= CNT_W'(DEPTH);
         channels_ff   <= 2'd2;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         fill_ff       <= '0;
         overrun_ff    <= '0;
         remain_ff     <= '0;
         verdict_ff    <= V_IDLE;
         offset_ff     <= '0;
         stamp_ff      <= '0;
         cont_ff       <= 1'b0;
         first_rd_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         capacity_ff   <= capacity_in;
         channels_ff   <= channels_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         fill_ff       <= fill_in;
         overrun_ff    <= overrun_in;
         remain_ff     <= remain_in;
         verdict_ff    <= verdict_in;
         offset_ff     <= offset_in;
         stamp_ff      <= stamp_in;
         cont_ff       <= cont_in;
         first_rd_ff   <= first_rd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blen_ff     <= blen_in;
      prev_pts_ff <= prev_pts_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- hdl/timestamped_audio_frame_fifo_unit.sv -----
// top level of the timestamped audio frame fifo
`timescale 1ns / 1ps

// Ring of up to 1024 audio frames, each one or two 32-bit samples plus a
// 64-bit timestamp. Write, drop-all and pointer-reset words each give one
// result word. A read request of N frames gives N result words at one per
// cycle unless rsp_stall holds a result, each fetched through the single
// registered read port of the frame ring; the next request word can be
// taken in the cycle after the last frame is loaded into the result
// register. A refused or zero-length read gives one result word. There is a
// single result register: a result that waits under rsp_stall holds the
// input off, and a new word is taken in the same cycle the previous result
// leaves. The user must write configuration (capacity at 0x0, channel count
// at 0x4) only while idle; the block does not enforce it. A capacity write
// drops any write block in progress. No clearing pass: ring has no reset state.

module timestamped_audio_frame_fifo_unit import tafifo_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_word,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_word,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   assign csr_pready = 1'b1;

   // sequencer
   tafifo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // ring, pointers and result register
   tafifo_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cmd         (cmd),
      .sts         (sts)
   );

   // no new word taken while frames of a read are still streaming
   a_no_accept_streaming: assert property (@(posedge clock) disable iff (reset)
      cmd.streaming |-> req_stall)
      else $error("request word taken during read streaming");

   // committed frame count never exceeds the ring
   a_queued_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.queued <= CNT_W'(DEPTH)))
      else $error("queued count beyond ring depth");

   // continuity flag only on the final word of a step
   a_cont_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.last) |-> !rsp_word.continuous)
      else $error("continuity flag on a non-final word");

   // a read frame load only happens with the result register free
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_load && rsp_valid) |-> !rsp_stall)
      else $error("result register overwritten while stalled");

endmodule
